/* hw/rtl/id3p_pkg.sv */
// Package with the shared types, codes and the frame id classifier of the ID3v2 tag parser.
`default_nettype none

package id3p_pkg;

    typedef struct packed {
        logic [7:0] tag_byte;
        logic       tag_start;
    } t_item;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] frame_id;
        logic [4:0]  frame_class;
        logic [27:0] frame_length;
        logic [15:0] frame_flag_bytes;
        logic [7:0]  content_byte;
        logic        frame_last;
    } t_result;

    typedef enum logic [2:0] {
        PH_HEAD,
        PH_EXTSIZE,
        PH_EXTSKIP,
        PH_FHDR,
        PH_CONTENT,
        PH_DONE
    } t_phase;

    localparam int MAX_RES = 3;

    localparam logic [1:0] KIND_FHDR    = 2'd0;
    localparam logic [1:0] KIND_CONTENT = 2'd1;
    localparam logic [1:0] KIND_END     = 2'd2;
    localparam logic [1:0] KIND_NOT_ID3 = 2'd3;

    localparam logic [4:0] CLS_GENERIC = 5'd0;
    localparam logic [4:0] CLS_TEXT    = 5'd1;
    localparam logic [4:0] CLS_COMMENT = 5'd2;
    localparam logic [4:0] CLS_APIC    = 5'd3;
    localparam logic [4:0] CLS_COMR    = 5'd4;
    localparam logic [4:0] CLS_ENCR    = 5'd5;
    localparam logic [4:0] CLS_EQU2    = 5'd6;
    localparam logic [4:0] CLS_LINK    = 5'd7;
    localparam logic [4:0] CLS_OWNE    = 5'd8;
    localparam logic [4:0] CLS_PCNT    = 5'd9;
    localparam logic [4:0] CLS_POPM    = 5'd10;
    localparam logic [4:0] CLS_POSS    = 5'd11;
    localparam logic [4:0] CLS_RBUF    = 5'd12;
    localparam logic [4:0] CLS_SEEK    = 5'd13;
    localparam logic [4:0] CLS_SYLT    = 5'd14;
    localparam logic [4:0] CLS_ETCO    = 5'd15;
    localparam logic [4:0] CLS_RVA2    = 5'd16;

    localparam logic [7:0]  MAGIC_0     = "I";
    localparam logic [7:0]  MAGIC_1     = "D";
    localparam logic [7:0]  MAGIC_2     = "3";
    localparam logic [7:0]  CHAR_T      = "T";
    localparam logic [7:0]  CHAR_W      = "W";
    localparam logic [7:0]  BYTE_FF     = 8'hFF;
    localparam logic [7:0]  BYTE_E0     = 8'hE0;
    localparam logic [27:0] HDR_LEN     = 28'd10;
    localparam logic [27:0] EXT_SIZE_LEN = 28'd4;

    function automatic logic [4:0] classify(input logic [31:0] id);
        logic [4:0] cls;
        cls = CLS_GENERIC;
        if (id[31:24] == CHAR_T || id[31:24] == CHAR_W || id == "PRIV" || id == "UFID") begin
            cls = CLS_TEXT;
        end else if (id == "USLT" || id == "COMM" || id == "USER") begin
            cls = CLS_COMMENT;
        end else if (id == "APIC") begin
            cls = CLS_APIC;
        end else if (id == "COMR") begin
            cls = CLS_COMR;
        end else if (id == "ENCR" || id == "GRID") begin
            cls = CLS_ENCR;
        end else if (id == "EQU2") begin
            cls = CLS_EQU2;
        end else if (id == "LINK") begin
            cls = CLS_LINK;
        end else if (id == "OWNE") begin
            cls = CLS_OWNE;
        end else if (id == "PCNT") begin
            cls = CLS_PCNT;
        end else if (id == "POPM") begin
            cls = CLS_POPM;
        end else if (id == "POSS") begin
            cls = CLS_POSS;
        end else if (id == "RBUF") begin
            cls = CLS_RBUF;
        end else if (id == "SEEK") begin
            cls = CLS_SEEK;
        end else if (id == "SYLT") begin
            cls = CLS_SYLT;
        end else if (id == "ETCO") begin
            cls = CLS_ETCO;
        end else if (id == "RVA2") begin
            cls = CLS_RVA2;
        end
        return cls;
    endfunction

    function automatic logic [27:0] sub_sat(input logic [27:0] a, input logic [28:0] b);
        logic [28:0] d;
        d = {1'b0, a} - b;
        return ({1'b0, a} > b) ? d[27:0] : 28'd0;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/id3p_parser.sv */
// Parser state and the per-byte step logic that produces up to three results.
`default_nettype none

module id3p_parser
    import id3p_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_step,
    input  wire t_item   i_item,
    output t_result      o_res [MAX_RES],
    output logic [1:0]   o_cnt
);

    t_phase      r_phase,   n_phase,   s_phase;
    logic [3:0]  r_fc,      n_fc,      s_fc;
    logic [27:0] r_tagrem,  n_tagrem,  s_tagrem;
    logic [27:0] r_extrem,  n_extrem,  s_extrem;
    logic [27:0] r_frmrem,  n_frmrem,  s_frmrem;
    logic [31:0] r_id,      n_id,      s_id;
    logic [27:0] r_size,    n_size,    s_size;
    logic [15:0] r_flags,   n_flags,   s_flags;
    logic        r_unsync,  n_unsync,  s_unsync;
    logic [7:0]  r_prev,    n_prev,    s_prev;
    logic        r_zheld,   n_zheld,   s_zheld;

    always_comb begin
        logic [7:0] b;
        logic [7:0] want;
        logic       last;
        logic       do_begin;
        logic       do_end;
        logic [1:0] cnt;
        t_result    res [MAX_RES];
        t_result    frame_res;

        b         = i_item.tag_byte;
        want      = MAGIC_0;
        last      = 1'b0;
        do_begin  = 1'b0;
        do_end    = 1'b0;
        cnt       = 2'd0;
        frame_res = '0;
        for (int k = 0; k < MAX_RES; k++) begin
            res[k] = '0;
        end

        // A start mark restarts the parser before the byte is taken.
        if (i_item.tag_start) begin
            s_phase = PH_HEAD; s_fc = '0; s_tagrem = '0; s_extrem = '0; s_frmrem = '0;
            s_id = '0; s_size = '0; s_flags = '0; s_unsync = 1'b0; s_prev = '0;
            s_zheld = 1'b0;
        end else begin
            s_phase = r_phase; s_fc = r_fc; s_tagrem = r_tagrem; s_extrem = r_extrem;
            s_frmrem = r_frmrem; s_id = r_id; s_size = r_size; s_flags = r_flags;
            s_unsync = r_unsync; s_prev = r_prev; s_zheld = r_zheld;
        end

        n_phase = s_phase; n_fc = s_fc; n_tagrem = s_tagrem; n_extrem = s_extrem;
        n_frmrem = s_frmrem; n_id = s_id; n_size = s_size; n_flags = s_flags;
        n_unsync = s_unsync; n_prev = s_prev; n_zheld = s_zheld;

        case (s_phase)
            PH_HEAD: begin
                if (s_fc <= 4'd2) begin
                    case (s_fc)
                        4'd0:    want = MAGIC_0;
                        4'd1:    want = MAGIC_1;
                        default: want = MAGIC_2;
                    endcase
                end else if (s_fc == 4'd5) begin
                    n_flags = {8'd0, b};
                end else if (s_fc >= 4'd6) begin
                    n_tagrem = {s_tagrem[20:0], b[6:0]};
                end
                if (s_fc <= 4'd2 && b != want) begin
                    res[cnt] = '{kind: KIND_NOT_ID3, default: '0};
                    cnt = cnt + 2'd1;
                    n_phase = PH_DONE;
                end else if (s_fc >= 4'd9) begin
                    n_unsync = n_flags[7];
                    if (n_flags[6]) begin
                        n_phase  = PH_EXTSIZE;
                        n_fc     = '0;
                        n_extrem = '0;
                    end else begin
                        do_begin = 1'b1;
                    end
                    n_flags = '0;
                end else begin
                    n_fc = s_fc + 4'd1;
                end
            end
            PH_EXTSIZE: begin
                n_extrem = {s_extrem[20:0], b[6:0]};
                if (s_fc >= 4'd3) begin
                    n_tagrem = sub_sat(s_tagrem, {1'b0, EXT_SIZE_LEN});
                    n_extrem = sub_sat(n_extrem, {1'b0, EXT_SIZE_LEN});
                    if (n_extrem == '0) begin
                        do_begin = 1'b1;
                    end else begin
                        n_phase = PH_EXTSKIP;
                    end
                end else begin
                    n_fc = s_fc + 4'd1;
                end
            end
            PH_EXTSKIP: begin
                n_tagrem = sub_sat(s_tagrem, 29'd1);
                n_extrem = sub_sat(s_extrem, 29'd1);
                if (n_extrem == '0) begin
                    do_begin = 1'b1;
                end
            end
            PH_FHDR: begin
                if (s_fc == 4'd0 && b == 8'd0) begin
                    // Padding: the frame area ends here.
                    res[cnt] = '{kind: KIND_END, default: '0};
                    cnt = cnt + 2'd1;
                    n_phase = PH_DONE;
                end else begin
                    if (s_fc == 4'd0) begin
                        n_id    = {24'd0, b};
                        n_size  = '0;
                        n_flags = '0;
                    end else if (s_fc <= 4'd3) begin
                        n_id = {s_id[23:0], b};
                    end else if (s_fc <= 4'd7) begin
                        n_size = {s_size[20:0], b[6:0]};
                    end else begin
                        n_flags = {s_flags[7:0], b};
                    end
                    if (s_fc >= 4'd9) begin
                        res[cnt] = '{kind: KIND_FHDR, frame_id: n_id,
                                     frame_class: classify(n_id), frame_length: n_size,
                                     frame_flag_bytes: n_flags, default: '0};
                        cnt = cnt + 2'd1;
                        n_frmrem = n_size;
                        n_prev   = '0;
                        n_zheld  = 1'b0;
                        if (n_size == '0) begin
                            do_end = 1'b1;
                        end else begin
                            n_phase = PH_CONTENT;
                        end
                    end else begin
                        n_fc = s_fc + 4'd1;
                    end
                end
            end
            PH_CONTENT: begin
                frame_res = '{kind: KIND_CONTENT, frame_id: s_id,
                              frame_class: classify(s_id), frame_length: s_size,
                              frame_flag_bytes: s_flags, default: '0};
                n_frmrem = sub_sat(s_frmrem, 29'd1);
                last = (n_frmrem == '0);
                if (s_zheld) begin
                    // The held zero is kept unless the byte after it is 0xE0 or above.
                    n_zheld = 1'b0;
                    if (b < BYTE_E0) begin
                        res[cnt] = frame_res;
                        cnt = cnt + 2'd1;
                    end
                    res[cnt] = frame_res;
                    res[cnt].content_byte = b;
                    res[cnt].frame_last   = last;
                    cnt = cnt + 2'd1;
                    n_prev = b;
                end else if (s_unsync && s_prev == BYTE_FF && b == 8'd0 && !last) begin
                    n_zheld = 1'b1;
                    n_prev  = '0;
                end else begin
                    res[cnt] = frame_res;
                    res[cnt].content_byte = b;
                    res[cnt].frame_last   = last;
                    cnt = cnt + 2'd1;
                    n_prev = b;
                end
                if (last) begin
                    do_end = 1'b1;
                end
            end
            default: begin
            end
        endcase

        if (do_end) begin
            n_tagrem = sub_sat(n_tagrem, {1'b0, n_size} + {1'b0, HDR_LEN});
            n_zheld  = 1'b0;
            do_begin = 1'b1;
        end
        if (do_begin) begin
            if (n_tagrem <= HDR_LEN) begin
                res[cnt] = '{kind: KIND_END, default: '0};
                cnt = cnt + 2'd1;
                n_phase = PH_DONE;
            end else begin
                n_phase = PH_FHDR;
                n_fc    = '0;
            end
        end

        o_res = res;
        o_cnt = cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HEAD;
            r_fc     <= '0;
            r_tagrem <= '0;
            r_extrem <= '0;
            r_frmrem <= '0;
            r_id     <= '0;
            r_size   <= '0;
            r_flags  <= '0;
            r_unsync <= 1'b0;
            r_prev   <= '0;
            r_zheld  <= 1'b0;
        end else if (i_step) begin
            r_phase  <= n_phase;
            r_fc     <= n_fc;
            r_tagrem <= n_tagrem;
            r_extrem <= n_extrem;
            r_frmrem <= n_frmrem;
            r_id     <= n_id;
            r_size   <= n_size;
            r_flags  <= n_flags;
            r_unsync <= n_unsync;
            r_prev   <= n_prev;
            r_zheld  <= n_zheld;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/id3p_outq.sv */
// Result register of up to three slots that hands results out one transfer at a time.
`default_nettype none

module id3p_outq
    import id3p_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_load,
    input  wire t_result i_res [MAX_RES],
    input  wire logic [1:0] i_cnt,
    output logic         o_ready,
    output logic         o_valid,
    output t_result      o_data,
    input  wire logic    i_stall
);

    t_result    r_res [MAX_RES];
    logic [1:0] r_cnt;
    logic       pop;

    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_res[0];
    assign pop     = o_valid && !i_stall;
    // A new group may enter once the slots are empty or the last one leaves now.
    assign o_ready = (r_cnt == 2'd0) || (r_cnt == 2'd1 && pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else if (i_load) begin
            r_cnt <= i_cnt;
        end else if (pop) begin
            r_cnt <= r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end else if (pop) begin
            r_res[0] <= r_res[1];
            r_res[1] <= r_res[2];
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/id3v2_tag_stream_parser.sv */
// Top level of the streaming ID3v2 tag parser: input register, parser and result register.
`default_nettype none

// Streaming ID3v2 tag parser. Each input transfer carries one raw tag byte and a start
// mark; each output transfer carries one result (frame header, content byte, end of tag
// or not an ID3 tag). A byte passes from the input register through the parser into a
// three-slot result register, from which its results leave in order. The block takes one
// byte per cycle as long as each byte yields at most one result and the output does not stall;
// a byte that yields two or three results (a released unsynchronisation zero, an end of tag
// after a frame) holds the next byte until the result register, which hands out one result
// per cycle while the output does not stall, is down to its last result.

module id3v2_tag_stream_parser
    import id3p_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    input  wire t_item   i_in_data,
    output logic         o_in_stall,
    output logic         o_out_valid,
    output t_result      o_out_data,
    input  wire logic    i_out_stall
);

    logic       r_in_valid;
    t_item      r_in_data;
    logic       q_ready;
    logic       step;
    t_result    res [MAX_RES];
    logic [1:0] cnt;

    assign step       = r_in_valid && q_ready;
    assign o_in_stall = r_in_valid && !q_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_valid && !o_in_stall) begin
            r_in_valid <= 1'b1;
        end else if (step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in_data <= i_in_data;
        end
    end

    id3p_parser u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_item  (r_in_data),
        .o_res   (res),
        .o_cnt   (cnt)
    );

    id3p_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (step),
        .i_res   (res),
        .i_cnt   (cnt),
        .o_ready (q_ready),
        .o_valid (o_out_valid),
        .o_data  (o_out_data),
        .i_stall (i_out_stall)
    );

endmodule

`default_nettype wire

/* bench/tb_id3v2_tag_stream_parser.sv */
// Self-checking testbench for the streaming ID3v2 tag parser, with its own parse predictor.
module tb_id3v2_tag_stream_parser;
    timeunit 1ns;
    timeprecision 1ps;

    import id3p_pkg::*;

    localparam int HOLD_CYCLES  = 200;
    localparam int DRAIN_CYCLES = 20;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int CHUNK_ITEMS  = 25;
    localparam int MAX_REPORTS  = 40;

    logic    i_clk = 1'b0;
    logic    i_rst_n = 1'b0;
    logic    i_in_valid = 1'b0;
    t_item   i_in_data = '0;
    logic    o_in_stall;
    logic    o_out_valid;
    t_result o_out_data;
    logic    i_out_stall = 1'b0;

    id3v2_tag_stream_parser i_dut (
        .i_clk,
        .i_rst_n,
        .i_in_valid,
        .i_in_data,
        .o_in_stall,
        .o_out_valid,
        .o_out_data,
        .i_out_stall
    );

    always #6 i_clk = ~i_clk;

    t_item   pending_bytes[$];
    t_result expected_results[$];
    int      queued_total = 0;
    int      mismatches = 0;
    int      cycle_count = 0;
    int      send_idle_pct = 0;
    int      recv_stall_pct = 0;
    int      hold_requests = 0;
    int      hold_served = 0;
    int      hold_left = 0;
    logic    in_taken = 1'b0;

    // Parser state as the predictor sees it.
    t_phase      parse_phase;
    logic [3:0]  field_idx;
    logic [27:0] tag_left;
    logic [27:0] ext_left;
    logic [27:0] frame_left;
    logic [31:0] cur_id;
    logic [27:0] cur_size;
    logic [15:0] cur_flags;
    logic        unsync_active;
    logic [7:0]  prev_content;
    logic        zero_pending;

    function automatic logic [7:0] magic_char(input int k);
        return (k == 0) ? MAGIC_0 : (k == 1) ? MAGIC_1 : MAGIC_2;
    endfunction

    function automatic logic [4:0] id_class(input logic [31:0] id);
        if (id[31:24] == CHAR_T || id[31:24] == CHAR_W) begin
            return CLS_TEXT;
        end
        case (id)
            "PRIV", "UFID":         return CLS_TEXT;
            "USLT", "COMM", "USER": return CLS_COMMENT;
            "APIC":                 return CLS_APIC;
            "COMR":                 return CLS_COMR;
            "ENCR", "GRID":         return CLS_ENCR;
            "EQU2":                 return CLS_EQU2;
            "LINK":                 return CLS_LINK;
            "OWNE":                 return CLS_OWNE;
            "PCNT":                 return CLS_PCNT;
            "POPM":                 return CLS_POPM;
            "POSS":                 return CLS_POSS;
            "RBUF":                 return CLS_RBUF;
            "SEEK":                 return CLS_SEEK;
            "SYLT":                 return CLS_SYLT;
            "ETCO":                 return CLS_ETCO;
            "RVA2":                 return CLS_RVA2;
            default:                return CLS_GENERIC;
        endcase
    endfunction

    function automatic logic [27:0] minus_floor(input logic [27:0] a, input logic [31:0] d);
        return ({4'h0, a} > d) ? 28'({4'h0, a} - d) : 28'd0;
    endfunction

    task automatic clear_parser();
        parse_phase   = PH_HEAD;
        field_idx     = '0;
        tag_left      = '0;
        ext_left      = '0;
        frame_left    = '0;
        cur_id        = '0;
        cur_size      = '0;
        cur_flags     = '0;
        unsync_active = 1'b0;
        prev_content  = '0;
        zero_pending  = 1'b0;
    endtask

    task automatic push_result(input logic [1:0] kind, input logic in_frame,
                               input logic [7:0] value, input logic is_last);
        t_result r;
        r = '0;
        r.kind = kind;
        if (in_frame) begin
            r.frame_id         = cur_id;
            r.frame_class      = id_class(cur_id);
            r.frame_length     = cur_size;
            r.frame_flag_bytes = cur_flags;
        end
        r.content_byte = value;
        r.frame_last   = is_last;
        expected_results = {expected_results, r};
    endtask

    // Ends the tag when ten or fewer bytes remain, else waits for the next frame header.
    task automatic open_frames();
        if (tag_left <= HDR_LEN) begin
            push_result(KIND_END, 1'b0, 8'h00, 1'b0);
            parse_phase = PH_DONE;
        end else begin
            parse_phase = PH_FHDR;
            field_idx   = '0;
        end
    endtask

    task automatic close_frame();
        tag_left     = minus_floor(tag_left, 32'(HDR_LEN) + 32'(cur_size));
        zero_pending = 1'b0;
        open_frames();
    endtask

    task automatic parse_byte(input t_item it);
        logic [7:0] b;
        logic       last;
        b = it.tag_byte;
        if (it.tag_start) begin
            clear_parser();
        end
        case (parse_phase)
            PH_HEAD: begin
                if (field_idx <= 2 && b != magic_char(int'(field_idx))) begin
                    push_result(KIND_NOT_ID3, 1'b0, 8'h00, 1'b0);
                    parse_phase = PH_DONE;
                end else begin
                    if (field_idx == 5) begin
                        cur_flags = {8'h00, b};
                    end else if (field_idx >= 6) begin
                        tag_left = {tag_left[20:0], b[6:0]};
                    end
                    if (field_idx >= 9) begin
                        unsync_active = cur_flags[7];
                        if (cur_flags[6]) begin
                            parse_phase = PH_EXTSIZE;
                            field_idx   = '0;
                            ext_left    = '0;
                        end else begin
                            open_frames();
                        end
                        cur_flags = '0;
                    end else begin
                        field_idx++;
                    end
                end
            end
            PH_EXTSIZE: begin
                ext_left = {ext_left[20:0], b[6:0]};
                if (field_idx >= 3) begin
                    // The extended size counts its own four bytes.
                    tag_left = minus_floor(tag_left, 32'(EXT_SIZE_LEN));
                    ext_left = minus_floor(ext_left, 32'(EXT_SIZE_LEN));
                    if (ext_left == 0) begin
                        open_frames();
                    end else begin
                        parse_phase = PH_EXTSKIP;
                    end
                end else begin
                    field_idx++;
                end
            end
            PH_EXTSKIP: begin
                tag_left = minus_floor(tag_left, 32'd1);
                ext_left = minus_floor(ext_left, 32'd1);
                if (ext_left == 0) begin
                    open_frames();
                end
            end
            PH_FHDR: begin
                if (field_idx == 0 && b == 8'h00) begin
                    push_result(KIND_END, 1'b0, 8'h00, 1'b0);
                    parse_phase = PH_DONE;
                end else begin
                    if (field_idx == 0) begin
                        cur_id    = {24'h0, b};
                        cur_size  = '0;
                        cur_flags = '0;
                    end else if (field_idx <= 3) begin
                        cur_id = {cur_id[23:0], b};
                    end else if (field_idx <= 7) begin
                        cur_size = {cur_size[20:0], b[6:0]};
                    end else begin
                        cur_flags = {cur_flags[7:0], b};
                    end
                    if (field_idx >= 9) begin
                        push_result(KIND_FHDR, 1'b1, 8'h00, 1'b0);
                        frame_left   = cur_size;
                        prev_content = '0;
                        zero_pending = 1'b0;
                        if (cur_size == 0) begin
                            close_frame();
                        end else begin
                            parse_phase = PH_CONTENT;
                        end
                    end else begin
                        field_idx++;
                    end
                end
            end
            PH_CONTENT: begin
                frame_left = minus_floor(frame_left, 32'd1);
                last = (frame_left == 0);
                if (zero_pending) begin
                    // A held zero is released unless the byte after it is 0xE0 or more.
                    zero_pending = 1'b0;
                    if (b < BYTE_E0) begin
                        push_result(KIND_CONTENT, 1'b1, 8'h00, 1'b0);
                    end
                    push_result(KIND_CONTENT, 1'b1, b, last);
                    prev_content = b;
                end else if (unsync_active && prev_content == BYTE_FF && b == 8'h00 && !last) begin
                    zero_pending = 1'b1;
                    prev_content = 8'h00;
                end else begin
                    push_result(KIND_CONTENT, 1'b1, b, last);
                    prev_content = b;
                end
                if (last) begin
                    close_frame();
                end
            end
            default: begin
            end
        endcase
    endtask

    task automatic queue_byte(input logic [7:0] value, input logic first);
        t_item it;
        it.tag_byte  = value;
        it.tag_start = first;
        pending_bytes = {pending_bytes, it};
        queued_total++;
    endtask

    task automatic queue_word(input logic [31:0] value);
        for (int k = 3; k >= 0; k--) begin
            queue_byte(value[8*k +: 8], 1'b0);
        end
    endtask

    // The top bit of each size byte is ignored by the parser, so it is random here.
    task automatic queue_syncsafe(input logic [27:0] value);
        for (int k = 3; k >= 0; k--) begin
            queue_byte({1'($urandom_range(0, 1)), value[7*k +: 7]}, 1'b0);
        end
    endtask

    function automatic logic [31:0] pick_frame_id();
        case ($urandom_range(0, 29))
            0:       return "TIT2";
            1:       return "WXXX";
            2:       return "PRIV";
            3:       return "UFID";
            4:       return "USLT";
            5:       return "COMM";
            6:       return "USER";
            7:       return "APIC";
            8:       return "COMR";
            9:       return "ENCR";
            10:      return "GRID";
            11:      return "EQU2";
            12:      return "LINK";
            13:      return "OWNE";
            14:      return "PCNT";
            15:      return "POPM";
            16:      return "POSS";
            17:      return "RBUF";
            18:      return "SEEK";
            19:      return "SYLT";
            20:      return "ETCO";
            21:      return "RVA2";
            22:      return "TALB";
            23:      return "APIX";
            24:      return "MCDI";
            default: return {8'($urandom_range(1, 255)), 24'($urandom)};
        endcase
    endfunction

    // Leans toward 0xFF, 0x00 and high bytes so unsynchronisation patterns show up often.
    function automatic logic [7:0] pick_content_byte();
        case ($urandom_range(0, 7))
            0, 1:    return BYTE_FF;
            2, 3:    return 8'h00;
            4:       return 8'($urandom_range(224, 255));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic queue_frame(input logic [31:0] id, input logic [27:0] size, input int n_content);
        queue_word(id);
        queue_syncsafe(size);
        queue_byte(8'($urandom_range(0, 255)), 1'b0);
        queue_byte(8'($urandom_range(0, 255)), 1'b0);
        repeat (n_content) queue_byte(pick_content_byte(), 1'b0);
    endtask

    task automatic queue_random_tag();
        int         clen[4];
        int         n_frames;
        int         mode;
        int         ext_size;
        int         body;
        int         tsize;
        logic [7:0] flags;
        flags    = 8'($urandom_range(0, 255));
        flags[6] = ($urandom_range(0, 3) == 0);
        ext_size = 0;
        body     = 0;
        if (flags[6]) begin
            ext_size = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 3) : $urandom_range(4, 9);
            body     = (ext_size > 4) ? ext_size : 4;
        end
        n_frames = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 3);
        for (int f = 0; f < n_frames; f++) begin
            clen[f] = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 12);
            body += 10 + clen[f];
        end
        // Exact size, size with padding, size too small, or the largest size cut by a new tag.
        mode = $urandom_range(0, 19);
        if (mode < 10) begin
            tsize = body + $urandom_range(0, 10);
        end else if (mode < 14) begin
            tsize = body + $urandom_range(11, 40);
        end else if (mode < 17) begin
            tsize = $urandom_range(0, body);
        end else begin
            tsize = 28'hFFFFFFF;
        end
        queue_byte(MAGIC_0, 1'b1);
        queue_byte(MAGIC_1, 1'b0);
        queue_byte(MAGIC_2, 1'b0);
        queue_byte(8'($urandom_range(0, 255)), 1'b0);
        queue_byte(8'($urandom_range(0, 255)), 1'b0);
        queue_byte(flags, 1'b0);
        queue_syncsafe(28'(tsize));
        if (flags[6]) begin
            queue_syncsafe(28'(ext_size));
            for (int k = 4; k < ext_size; k++) begin
                queue_byte(8'($urandom_range(0, 255)), 1'b0);
            end
        end
        for (int f = 0; f < n_frames; f++) begin
            queue_frame(pick_frame_id(), 28'(clen[f]), clen[f]);
        end
        if (mode >= 10 && mode < 14) begin
            queue_byte(8'h00, 1'b0);
            repeat ($urandom_range(0, 2)) queue_byte(8'($urandom_range(0, 255)), 1'b0);
        end else if (mode >= 17 && $urandom_range(0, 1) == 1) begin
            queue_frame(pick_frame_id(), 28'hFFFFFFF, $urandom_range(1, 4));
        end
    endtask

    task automatic queue_noise();
        int         depth;
        logic [7:0] wrong;
        depth = $urandom_range(0, 3);
        if (depth == 3) begin
            repeat ($urandom_range(1, 4)) begin
                queue_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 3) == 0));
            end
        end else begin
            // A magic that breaks at the chosen byte, followed by bytes that are ignored.
            wrong = 8'($urandom_range(0, 255));
            for (int k = 0; k < depth; k++) begin
                queue_byte(magic_char(k), k == 0);
            end
            if (wrong == magic_char(depth)) begin
                wrong ^= 8'h01;
            end
            queue_byte(wrong, depth == 0);
            repeat ($urandom_range(0, 2)) queue_byte(8'($urandom_range(0, 255)), 1'b0);
        end
    endtask

    task automatic check_field(input string label, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
                $display("%0t: %s mismatch, expected %h, actual %h", $time, label, want, got);
            end
        end
    endtask

    // Input side: offer the next byte once the previous transfer has completed.
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_in_valid || in_taken)) begin
            if (pending_bytes.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                i_in_valid <= 1'b1;
                i_in_data  <= pending_bytes.pop_front();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Output side: random stalls, plus one long hold-off on request.
    always @(negedge i_clk) begin
        if (hold_left != 0) begin
            i_out_stall <= 1'b1;
            hold_left   <= hold_left - 1;
        end else if (hold_requests != hold_served) begin
            hold_served <= hold_requests;
            hold_left   <= HOLD_CYCLES;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("%0t: unexpected result, expected none, actual %h",
                                 $time, o_out_data);
                    end
                end else begin
                    want = expected_results.pop_front();
                    check_field("kind", want.kind, o_out_data.kind);
                    check_field("frame_id", want.frame_id, o_out_data.frame_id);
                    check_field("frame_class", want.frame_class, o_out_data.frame_class);
                    check_field("frame_length", want.frame_length, o_out_data.frame_length);
                    check_field("frame_flag_bytes", want.frame_flag_bytes,
                                o_out_data.frame_flag_bytes);
                    check_field("content_byte", want.content_byte, o_out_data.content_byte);
                    check_field("frame_last", want.frame_last, o_out_data.frame_last);
                end
            end
            in_taken <= i_in_valid && !o_in_stall;
            if (i_in_valid && !o_in_stall) begin
                parse_byte(i_in_data);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        int send_idle_by_phase[4];
        int recv_stall_by_phase[4];
        int goal;
        send_idle_by_phase  = '{0, 62, 0, 20};
        recv_stall_by_phase = '{0, 0, 62, 20};
        clear_parser();
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct  = send_idle_by_phase[ph];
            recv_stall_pct = recv_stall_by_phase[ph];
            if (ph == 0) begin
                // A tag whose first byte carries no start mark, with unsynchronisation on and
                // one COMM frame: a zero dropped before 0xE5 and a zero as the last byte.
                queue_byte(MAGIC_0, 1'b0);
                queue_byte(MAGIC_1, 1'b0);
                queue_byte(MAGIC_2, 1'b0);
                queue_byte(8'h04, 1'b0);
                queue_byte(8'h00, 1'b0);
                queue_byte(8'h80, 1'b0);
                queue_syncsafe(28'd15);
                queue_word("COMM");
                queue_syncsafe(28'd5);
                queue_byte(8'h00, 1'b0);
                queue_byte(8'h00, 1'b0);
                queue_byte(BYTE_FF, 1'b0);
                queue_byte(8'h00, 1'b0);
                queue_byte(8'hE5, 1'b0);
                queue_byte(BYTE_FF, 1'b0);
                queue_byte(8'h00, 1'b0);
                // Ignored after the end of the tag, then a bad first magic byte.
                queue_byte(8'h55, 1'b0);
                queue_byte("J", 1'b1);
                // The receiver holds off while the sender keeps going, so the block backs up.
                hold_requests++;
            end
            goal = queued_total + CHUNK_ITEMS;
            while (queued_total < goal) begin
                if ($urandom_range(0, 6) == 0) begin
                    queue_noise();
                end else begin
                    queue_random_tag();
                end
            end
            // Let every transfer and every expected result finish before the next phase.
            while (pending_bytes.size() != 0 || i_in_valid || expected_results.size() != 0) begin
                @(negedge i_clk);
            end
        end
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
